FILE: src/a2p_pkg.sv
package a2p_pkg;

  // Default configuration of the top level.
  localparam int INPUT_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Output format: signed Q3.13 radians, clamped to +-pi.
  localparam int OUT_WIDTH = 16;
  localparam int OUT_FRAC  = 13;
  localparam int ANGLE_MAX = 25736;

  // Horner steps after the leading coefficient.
  localparam int HORNER_STAGES = 5;

  // Polynomial coefficients, highest power first, scaled by 2^32.
  localparam logic [63:0] COEF32 [HORNER_STAGES+1] = '{
    64'd57898178,
    64'd246863184,
    64'd520717845,
    64'd840249900,
    64'd1430200904,
    64'd4294948527
  };
  localparam logic [63:0] HALF_PI32 = 64'd6746518853;
  localparam logic [63:0] PI32      = 64'd13493037706;

  // Per-request side information that travels with the data.
  typedef struct packed {
    logic zero;
    logic swap;
    logic x_neg;
    logic y_neg;
  } a2p_quad_t;

  // Requantizes a 2^32 scaled constant to frac fraction bits, rounding half up.
  function automatic logic [63:0] quant(input logic [63:0] v32, input int frac);
    quant = (v32 + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

endpackage

FILE: src/a2p_div.sv
module a2p_div
  import a2p_pkg::*;
#(
  parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  a2p_quad_t              side_i,
  input  logic [INPUT_WIDTH-1:0] mn_i,
  input  logic [INPUT_WIDTH-1:0] mx_i,
  output logic                   valid_o,
  output a2p_quad_t              side_o,
  output logic [FRAC_BITS:0]     quot_o
);

  localparam int W = INPUT_WIDTH;
  localparam int F = FRAC_BITS;

  // Restoring division, one quotient bit per stage, most significant first.
  logic [W-1:0] rem_q  [F];
  logic [W-1:0] mx_q   [F];
  logic [F:0]   quot_q [F];
  logic         vld_q  [F];
  a2p_quad_t    side_q [F];

  for (genvar s = 0; s < F; s++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [W-1:0] mx_in;
    logic [F:0]   quot_in;
    logic         vld_in;
    a2p_quad_t    side_in;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_in  = mn_i;
      assign mx_in   = mx_i;
      assign quot_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
      assign trial   = {1'b0, rem_in};
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign mx_in   = mx_q[s-1];
      assign quot_in = quot_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
      assign trial   = {rem_in, 1'b0};
    end

    assign diff = trial - {1'b0, mx_in};
    assign ge   = (trial >= {1'b0, mx_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[W-1:0] : trial[W-1:0];
        mx_q[s]   <= mx_in;
        quot_q[s] <= quot_in | ((F+1)'(ge) << (F - s));
        side_q[s] <= side_in;
      end
    end
  end

  // The last quotient bit needs only the compare.
  logic [W:0] last_trial;
  logic       last_ge;

  assign last_trial = {rem_q[F-1], 1'b0};
  assign last_ge    = (last_trial >= {1'b0, mx_q[F-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[F-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_o <= quot_q[F-1] | (F+1)'(last_ge);
      side_o <= side_q[F-1];
    end
  end

endmodule

FILE: src/a2p_horner.sv
module a2p_horner
  import a2p_pkg::*;
#(
  parameter int                    FRAC_BITS = FRAC_BITS_DEF,
  parameter int                    PW        = FRAC_BITS_DEF + 3,
  parameter logic signed [PW-1:0]  COEF      = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  a2p_quad_t            side_i,
  input  logic signed [PW-1:0] p_i,
  input  logic [FRAC_BITS:0]   t_i,
  input  logic [FRAC_BITS:0]   r_i,
  output logic                 valid_o,
  output a2p_quad_t            side_o,
  output logic signed [PW-1:0] p_o,
  output logic [FRAC_BITS:0]   t_o,
  output logic [FRAC_BITS:0]   r_o
);

  localparam int F = FRAC_BITS;

  logic                 neg;
  logic signed [PW-1:0] p_neg;
  logic [PW-2:0]        mag;
  logic [PW+F-1:0]      prod;
  logic [PW+F:0]        prod_rnd;
  logic [PW-1:0]        rnd;
  logic signed [PW-1:0] term;
  logic signed [PW-1:0] p_d;

  // One Horner step: p * t rounded half away from zero, plus the coefficient.
  always_comb begin
    neg      = p_i[PW-1];
    p_neg    = -p_i;
    mag      = neg ? p_neg[PW-2:0] : p_i[PW-2:0];
    prod     = mag * t_i;
    prod_rnd = {1'b0, prod} + ((PW+F+1)'(1) << (F - 1));
    rnd      = prod_rnd[F +: PW];
    term     = neg ? -$signed(rnd) : $signed(rnd);
    p_d      = term + COEF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      p_o    <= p_d;
      t_o    <= t_i;
      r_o    <= r_i;
    end
  end

endmodule

FILE: src/atan2_polynomial_approx.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | y_comp_i, x_comp_i (signed)
// out     | output    | out_valid_o / out_stall_i | angle_o (signed Q3.13 radians)
//
// One request is taken every clock cycle unless the pipeline holds.
// The pipeline is an input stage, the restoring divider, one quotient bit per
// stage, the square, five Horner multiply stages and three output stages.
// Reset clears all valid bits; payload registers are not reset.
// When the output register holds a result and out_stall_i is high, the whole
// pipeline holds and in_stall_o is raised; otherwise requests keep flowing.
module atan2_polynomial_approx
  import a2p_pkg::*;
#(
  parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [INPUT_WIDTH-1:0] y_comp_i,
  input  logic signed [INPUT_WIDTH-1:0] x_comp_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_WIDTH-1:0]   angle_o
);

  localparam int W   = INPUT_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = F + 3;
  localparam int AW  = F + 4;
  localparam int SHR = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int SHL = (F < OUT_FRAC) ? OUT_FRAC - F : 0;

  localparam logic signed [PW-1:0] P_INIT  = -PW'(quant(COEF32[0], F));
  localparam logic signed [AW-1:0] HALF_PI = AW'(quant(HALF_PI32, F));
  localparam logic signed [AW-1:0] PI_Q    = AW'(quant(PI32, F));
  localparam logic [AW:0]          RND     = (AW+1)'(1 << SHR) >> 1;

  logic en;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 0: magnitudes, octant decision, operands of the ratio.
  logic [W-1:0] y_neg_v;
  logic [W-1:0] x_neg_v;
  logic [W-1:0] ay;
  logic [W-1:0] ax;
  a2p_quad_t    in_side;

  always_comb begin
    y_neg_v       = -y_comp_i;
    x_neg_v       = -x_comp_i;
    ay            = y_comp_i[W-1] ? y_neg_v : y_comp_i;
    ax            = x_comp_i[W-1] ? x_neg_v : x_comp_i;
    in_side.zero  = (ay == '0) && (ax == '0);
    in_side.swap  = (ay > ax);
    in_side.x_neg = x_comp_i[W-1];
    in_side.y_neg = y_comp_i[W-1];
  end

  logic         s0_vld_q;
  a2p_quad_t    s0_side_q;
  logic [W-1:0] s0_mn_q;
  logic [W-1:0] s0_mx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q <= in_side;
      s0_mn_q   <= in_side.swap ? ax : ay;
      s0_mx_q   <= in_side.swap ? ay : ax;
    end
  end

  // Ratio r = min / max in Q1.F.
  logic      div_vld;
  a2p_quad_t div_side;
  logic [F:0] div_quot;

  a2p_div #(
    .INPUT_WIDTH (INPUT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_vld_q),
    .side_i  (s0_side_q),
    .mn_i    (s0_mn_q),
    .mx_i    (s0_mx_q),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quot_o  (div_quot)
  );

  // Square stage: t = r * r, rounded half up.
  logic [2*F+1:0] sq;
  logic [2*F+1:0] sq_rnd;

  always_comb begin
    sq     = (2*F+2)'(div_quot) * (2*F+2)'(div_quot);
    sq_rnd = sq + ((2*F+2)'(1) << (F - 1));
  end

  logic                 p_vld  [HORNER_STAGES+1];
  a2p_quad_t            p_side [HORNER_STAGES+1];
  logic signed [PW-1:0] p_c    [HORNER_STAGES+1];
  logic [F:0]           t_c    [HORNER_STAGES];
  logic [F:0]           r_c    [HORNER_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld[0] <= 1'b0;
    end else if (en) begin
      p_vld[0] <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side[0] <= div_side;
      t_c[0]    <= sq_rnd[F +: F+1];
      r_c[0]    <= div_quot;
    end
  end

  assign p_c[0] = P_INIT;

  // Horner chain; the coefficient signs alternate.
  for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_horner
    localparam logic [PW-1:0]        CQ = PW'(quant(COEF32[k+1], F));
    localparam logic signed [PW-1:0] CS = (k % 2 == 0) ? $signed(CQ) : -$signed(CQ);

    if (k < HORNER_STAGES - 1) begin : g_mid
      a2p_horner #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW),
        .COEF      (CS)
      ) u_horner (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (p_vld[k]),
        .side_i  (p_side[k]),
        .p_i     (p_c[k]),
        .t_i     (t_c[k]),
        .r_i     (r_c[k]),
        .valid_o (p_vld[k+1]),
        .side_o  (p_side[k+1]),
        .p_o     (p_c[k+1]),
        .t_o     (t_c[k+1]),
        .r_o     (r_c[k+1])
      );
    end else begin : g_last
      a2p_horner #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW),
        .COEF      (CS)
      ) u_horner (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (p_vld[k]),
        .side_i  (p_side[k]),
        .p_i     (p_c[k]),
        .t_i     (t_c[k]),
        .r_i     (r_c[k]),
        .valid_o (p_vld[k+1]),
        .side_o  (p_side[k+1]),
        .p_o     (p_c[k+1]),
        .t_o     (),
        .r_o     (r_c[k+1])
      );
    end
  end

  // Angle within the first octant: a = p * r, rounded half away from zero.
  logic                 a_neg;
  logic signed [PW-1:0] a_pneg;
  logic [PW-2:0]        a_mag;
  logic [PW+F-1:0]      a_prod;
  logic [PW+F:0]        a_prod_rnd;
  logic [PW-1:0]        a_rnd;
  logic signed [PW-1:0] a_d;

  always_comb begin
    a_neg      = p_c[HORNER_STAGES][PW-1];
    a_pneg     = -p_c[HORNER_STAGES];
    a_mag      = a_neg ? a_pneg[PW-2:0] : p_c[HORNER_STAGES][PW-2:0];
    a_prod     = a_mag * r_c[HORNER_STAGES];
    a_prod_rnd = {1'b0, a_prod} + ((PW+F+1)'(1) << (F - 1));
    a_rnd      = a_prod_rnd[F +: PW];
    a_d        = a_neg ? -$signed(a_rnd) : $signed(a_rnd);
  end

  logic                 a_vld_q;
  a2p_quad_t            a_side_q;
  logic signed [PW-1:0] a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= p_vld[HORNER_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= p_side[HORNER_STAGES];
      a_q      <= a_d;
    end
  end

  // Reflection into the proper half plane; the y sign is applied last.
  logic signed [AW-1:0] a_ext;
  logic signed [AW-1:0] v_oct;
  logic signed [AW-1:0] v_d;

  always_comb begin
    a_ext = AW'(a_q);
    v_oct = a_side_q.swap ? HALF_PI - a_ext : a_ext;
    v_d   = a_side_q.x_neg ? PI_Q - v_oct : v_oct;
  end

  logic                 v_vld_q;
  a2p_quad_t            v_side_q;
  logic signed [AW-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
    end else if (en) begin
      v_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_side_q <= a_side_q;
      v_q      <= v_d;
    end
  end

  // Conversion to Q3.13 with rounding half away from zero and clamping.
  logic                        o_neg;
  logic signed [AW-1:0]        v_neg;
  logic [AW-1:0]               v_mag;
  logic [AW:0]                 m_rnd;
  logic [OUT_WIDTH-1:0]        m_sat;
  logic signed [OUT_WIDTH-1:0] angle_d;

  always_comb begin
    o_neg = v_q[AW-1] ^ v_side_q.y_neg;
    v_neg = -v_q;
    v_mag = v_q[AW-1] ? v_neg : v_q;
    m_rnd = (({1'b0, v_mag} + RND) >> SHR) << SHL;
    if (m_rnd > (AW+1)'(ANGLE_MAX)) begin
      m_sat = OUT_WIDTH'(ANGLE_MAX);
    end else begin
      m_sat = m_rnd[OUT_WIDTH-1:0];
    end
    if (v_side_q.zero) begin
      angle_d = '0;
    end else if (o_neg) begin
      angle_d = -$signed(m_sat);
    end else begin
      angle_d = $signed(m_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_o <= angle_d;
    end
  end

endmodule

FILE: src/a2p_chk.sv
module a2p_chk
  import a2p_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [OUT_WIDTH-1:0] angle_o
);

  // A result held against a stall keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_o))
    else $error("stalled result changed");

  // Results never leave the range -pi .. pi.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(angle_o) <= ANGLE_MAX) && ($signed(angle_o) >= -ANGLE_MAX))
    else $error("angle out of range");

  // The input side is held back only by a blocked result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // No result is presented at the clock edge where reset is seen released.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind atan2_polynomial_approx a2p_chk u_a2p_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .angle_o     (angle_o)
);
